[rtl/cfp_pkg.sv]
package cfp_pkg;

  // Payload bytes that are kept per frame
  localparam int unsigned STORE_BYTES = 20;
  localparam int unsigned IDX_W       = $clog2(STORE_BYTES);

  // Word queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // Config register indexes
  localparam logic REG_MIN_LEN = 1'b0;
  localparam logic REG_MAX_LEN = 1'b1;

  // Reset values of the length bounds
  localparam logic [7:0] MIN_LEN_RST = 8'd4;
  localparam logic [7:0] MAX_LEN_RST = 8'd30;

  // Sync word "CMD"
  localparam logic [7:0] SYNC_C = 8'h43;
  localparam logic [7:0] SYNC_M = 8'h4D;
  localparam logic [7:0] SYNC_D = 8'h44;

  // Command type words, first byte in the low lane
  localparam logic [31:0] TYPE_TAKE = {8'h45, 8'h4B, 8'h41, 8'h54};
  localparam logic [31:0] TYPE_LAND = {8'h44, 8'h4E, 8'h41, 8'h4C};
  localparam logic [31:0] TYPE_PCMD = {8'h44, 8'h4D, 8'h43, 8'h50};
  localparam logic [31:0] TYPE_ROTZ = {8'h5A, 8'h54, 8'h4F, 8'h52};

  // Command kinds
  typedef enum logic [2:0] {
    KIND_TAKE    = 3'd0,
    KIND_LAND    = 3'd1,
    KIND_MOVE    = 3'd2,
    KIND_ROTATE  = 3'd3,
    KIND_UNKNOWN = 3'd4
  } kind_t;

  // Token from the front to the back
  typedef struct packed {
    logic             clr;   // frame start: clear the store
    logic             wr;    // write data into the store
    logic [IDX_W-1:0] idx;   // store slot
    logic [7:0]       data;
    logic             last;  // frame ends with this token
  } token_t;

endpackage

[rtl/cfp_front.sv]
module cfp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      min_len,
  input  logic [7:0]      max_len,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_rx_byte,
  input  logic            q_full,
  output logic            tok_push,
  output cfp_pkg::token_t tok
);

  typedef enum logic [1:0] {
    ST_HUNT = 2'd0,
    ST_LEN  = 2'd1,
    ST_DATA = 2'd2
  } state_t;

  localparam logic [7:0] SYNC_C_L = cfp_pkg::SYNC_C;

  state_t     state_r, state_nxt;
  logic [1:0] sync_pos_r, sync_pos_nxt;
  logic [7:0] frame_len_r, frame_len_nxt;
  logic [7:0] byte_cnt_r, byte_cnt_nxt;
  logic [7:0] cnt_inc;
  logic [7:0] sync_exp;
  logic       take;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign cnt_inc  = byte_cnt_r + 8'd1;

  // Expected sync byte at the current position
  always_comb begin
    unique case (sync_pos_r)
      2'd0:    sync_exp = SYNC_C_L;
      2'd1:    sync_exp = cfp_pkg::SYNC_M;
      2'd2:    sync_exp = cfp_pkg::SYNC_D;
      default: sync_exp = SYNC_C_L;
    endcase
  end

  // Byte classification
  always_comb begin
    state_nxt     = state_r;
    sync_pos_nxt  = sync_pos_r;
    frame_len_nxt = frame_len_r;
    byte_cnt_nxt  = byte_cnt_r;
    tok_push      = 1'b0;
    tok           = '0;
    tok.data      = in_rx_byte;
    tok.idx       = byte_cnt_r[cfp_pkg::IDX_W-1:0];
    if (take) begin
      unique case (state_r)
        ST_LEN: begin
          if (in_rx_byte >= min_len && in_rx_byte <= max_len) begin
            frame_len_nxt = in_rx_byte;
            byte_cnt_nxt  = 8'd0;
            tok_push      = 1'b1;
            tok.clr       = 1'b1;
            if (in_rx_byte == 8'd0) begin
              tok.last  = 1'b1;
              state_nxt = ST_HUNT;
            end else begin
              state_nxt = ST_DATA;
            end
          end else begin
            state_nxt = ST_HUNT;
          end
          sync_pos_nxt = 2'd0;
        end
        ST_DATA: begin
          tok_push     = 1'b1;
          tok.wr       = (byte_cnt_r < 8'(cfp_pkg::STORE_BYTES));
          byte_cnt_nxt = cnt_inc;
          if (cnt_inc == frame_len_r) begin
            tok.last     = 1'b1;
            state_nxt    = ST_HUNT;
            sync_pos_nxt = 2'd0;
          end
        end
        default: begin
          // hunting for the sync word
          state_nxt = ST_HUNT;
          if (sync_pos_r != 2'd3 && in_rx_byte == sync_exp) begin
            if (sync_pos_r == 2'd2) begin
              sync_pos_nxt = 2'd0;
              state_nxt    = ST_LEN;
            end else begin
              sync_pos_nxt = sync_pos_r + 2'd1;
            end
          end else if (in_rx_byte == cfp_pkg::SYNC_C) begin
            sync_pos_nxt = 2'd1;
          end else begin
            sync_pos_nxt = 2'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HUNT;
      sync_pos_r  <= 2'd0;
      frame_len_r <= 8'd0;
      byte_cnt_r  <= 8'd0;
    end else begin
      state_r     <= state_nxt;
      sync_pos_r  <= sync_pos_nxt;
      frame_len_r <= frame_len_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
    end
  end

endmodule

[rtl/cfp_queue.sv]
module cfp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cfp_pkg::token_t push_tok,
  input  logic            pop,
  output logic            full,
  output logic            nonempty,
  output cfp_pkg::token_t head_tok
);

  cfp_pkg::token_t             mem_r [cfp_pkg::QDEPTH];
  logic [cfp_pkg::QAW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [cfp_pkg::QAW:0]       count_r;
  logic                        do_push, do_pop;

  assign full     = (count_r == (cfp_pkg::QAW+1)'(cfp_pkg::QDEPTH));
  assign nonempty = (count_r != '0);
  assign head_tok = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[rtl/cfp_back.sv]
module cfp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            tok_valid,
  input  cfp_pkg::token_t tok,
  output logic            tok_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      out_kind,
  output logic [31:0]     out_value_a,
  output logic [31:0]     out_value_b,
  output logic [31:0]     out_value_c,
  output logic [31:0]     out_value_d,
  output logic            out_moving
);

  logic [7:0]     store_r   [cfp_pkg::STORE_BYTES];
  logic [7:0]     store_nxt [cfp_pkg::STORE_BYTES];
  logic           out_valid_r;
  logic [2:0]     kind_r;
  logic [31:0]    val_r [4];
  logic           moving_r;
  logic [31:0]    type_w;
  logic [31:0]    val_w [4];
  cfp_pkg::kind_t kind_w;
  logic           nz_w;
  logic           emit;

  assign tok_pop = tok_valid && (!tok.last || !out_valid_r || out_ready);
  assign emit    = tok_pop && tok.last;

  // store update for this token
  always_comb begin
    for (int i = 0; i < cfp_pkg::STORE_BYTES; i++) begin
      if (tok_pop && tok.clr) begin
        store_nxt[i] = 8'd0;
      end else if (tok_pop && tok.wr && tok.idx == cfp_pkg::IDX_W'(i)) begin
        store_nxt[i] = tok.data;
      end else begin
        store_nxt[i] = store_r[i];
      end
    end
  end

  // classify and gather words from the updated store
  always_comb begin
    type_w = {store_nxt[3], store_nxt[2], store_nxt[1], store_nxt[0]};
    for (int w = 0; w < 4; w++) begin
      val_w[w] = {store_nxt[4*w+7], store_nxt[4*w+6], store_nxt[4*w+5], store_nxt[4*w+4]};
    end
    priority if (type_w == cfp_pkg::TYPE_TAKE) kind_w = cfp_pkg::KIND_TAKE;
    else if (type_w == cfp_pkg::TYPE_LAND)     kind_w = cfp_pkg::KIND_LAND;
    else if (type_w == cfp_pkg::TYPE_PCMD)     kind_w = cfp_pkg::KIND_MOVE;
    else if (type_w == cfp_pkg::TYPE_ROTZ)     kind_w = cfp_pkg::KIND_ROTATE;
    else                                       kind_w = cfp_pkg::KIND_UNKNOWN;
    // any word other than +0 / -0
    nz_w = (|val_w[0][30:0]) || (|val_w[1][30:0]) || (|val_w[2][30:0]) || (|val_w[3][30:0]);
  end

  // payload store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cfp_pkg::STORE_BYTES; i++) store_r[i] <= 8'd0;
    end else begin
      for (int i = 0; i < cfp_pkg::STORE_BYTES; i++) store_r[i] <= store_nxt[i];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r   <= kind_w;
      val_r    <= val_w;
      moving_r <= (kind_w == cfp_pkg::KIND_MOVE) && nz_w;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = kind_r;
  assign out_value_a = val_r[0];
  assign out_value_b = val_r[1];
  assign out_value_c = val_r[2];
  assign out_value_d = val_r[3];
  assign out_moving  = moving_r;

endmodule

[rtl/command_frame_parser.sv]
// Command frame parser: one received byte per cycle, no gaps, while the token queue has room.
// A frame's result shows on out_valid once its final byte (or its length byte, for an
// empty frame) has passed through the token queue and the back end's output register.
// Throughput: one byte per cycle; the four-word front/back queue stalls in_ready
// only when it fills behind a result that waits on out_ready.
// Reset (synchronous, rst_n low): hunt restarts, queue, output, store clear, bounds 4/30.
module command_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [31:0] out_value_a,
  output logic [31:0] out_value_b,
  output logic [31:0] out_value_c,
  output logic [31:0] out_value_d,
  output logic        out_moving,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]      min_len_r, max_len_r;
  logic            cfg_wr;
  logic            tok_push, tok_pop, q_full, q_nonempty;
  cfp_pkg::token_t push_tok, head_tok;

  // config registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= cfp_pkg::MIN_LEN_RST;
      max_len_r <= cfp_pkg::MAX_LEN_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        cfp_pkg::REG_MIN_LEN: min_len_r <= pwdata[7:0];
        cfp_pkg::REG_MAX_LEN: max_len_r <= pwdata[7:0];
        default:              min_len_r <= min_len_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      cfp_pkg::REG_MIN_LEN: prdata = {24'd0, min_len_r};
      cfp_pkg::REG_MAX_LEN: prdata = {24'd0, max_len_r};
      default:              prdata = 32'd0;
    endcase
  end

  cfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .min_len    (min_len_r),
    .max_len    (max_len_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .tok_push   (tok_push),
    .tok        (push_tok)
  );

  cfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (tok_push),
    .push_tok (push_tok),
    .pop      (tok_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head_tok (head_tok)
  );

  cfp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .tok_valid   (q_nonempty),
    .tok         (head_tok),
    .tok_pop     (tok_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_value_a (out_value_a),
    .out_value_b (out_value_b),
    .out_value_c (out_value_c),
    .out_value_d (out_value_d),
    .out_moving  (out_moving)
  );

endmodule

[rtl/cfp_checker.sv]
module cfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [31:0] out_value_a,
  input logic [31:0] out_value_b,
  input logic [31:0] out_value_c,
  input logic [31:0] out_value_d,
  input logic        out_moving,
  input logic        pready
);

  // a stalled result holds its valid, kind, moving flag and values a and d
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_moving)
      && $stable(out_value_a) && $stable(out_value_d))
    else $error("stalled result changed");

  // kind code is always a defined command
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind <= cfp_pkg::KIND_UNKNOWN)
    else $error("kind out of range");

  // moving only on move commands
  a_moving_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_moving |-> out_kind == cfp_pkg::KIND_MOVE)
    else $error("moving set on non-move command");

  // move with a nonzero word must flag moving
  a_moving_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == cfp_pkg::KIND_MOVE
      && ((|out_value_a[30:0]) || (|out_value_b[30:0])
       || (|out_value_c[30:0]) || (|out_value_d[30:0])) |-> out_moving)
    else $error("moving flag missing");

  // config port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind command_frame_parser cfp_checker u_cfp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_kind    (out_kind),
  .out_value_a (out_value_a),
  .out_value_b (out_value_b),
  .out_value_c (out_value_c),
  .out_value_d (out_value_d),
  .out_moving  (out_moving),
  .pready      (pready)
);

[tb/command_frame_parser_tb.sv]
`timescale 1ns / 1ps

module command_frame_parser_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int HOLD_AT_WORD   = 300;
  localparam int SETTLE_CYCLES  = 8;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } parse_phase_t;

  typedef struct {
    cfp_pkg::kind_t kind;
    logic [31:0]    value_a;
    logic [31:0]    value_b;
    logic [31:0]    value_c;
    logic [31:0]    value_d;
    logic           moving;
  } command_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [31:0] out_value_a;
  logic [31:0] out_value_b;
  logic [31:0] out_value_c;
  logic [31:0] out_value_d;
  logic        out_moving;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the parser: bounds and frame state
  logic [7:0]   min_len;
  logic [7:0]   max_len;
  parse_phase_t parse_phase;
  logic [1:0]   sync_pos;
  logic [7:0]   frame_len;
  logic [7:0]   body_count;
  logic [7:0]   body_bytes [cfp_pkg::STORE_BYTES];

  logic [7:0] rx_stream [$];
  command_t   expected_commands [$];

  int  error_count    = 0;
  int  words_taken    = 0;
  int  commands_seen  = 0;
  int  moves_seen     = 0;
  int  bound_writes   = 0;
  int  words_queued   = 0;
  int  idle_cycles    = 0;
  int  send_gap       = 0;
  int  recv_stall     = 0;
  int  hold_left      = 0;
  bit  hold_done      = 1'b0;
  bit  quiet          = 1'b0;

  always #5 clk = ~clk;

  command_frame_parser i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (out_kind),
    .out_value_a(out_value_a),
    .out_value_b(out_value_b),
    .out_value_c(out_value_c),
    .out_value_d(out_value_d),
    .out_moving (out_moving),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic clear_parser_state();
    min_len     = cfp_pkg::MIN_LEN_RST;
    max_len     = cfp_pkg::MAX_LEN_RST;
    parse_phase = PH_HUNT;
    sync_pos    = 2'd0;
    frame_len   = 8'd0;
    body_count  = 8'd0;
    for (int i = 0; i < cfp_pkg::STORE_BYTES; i++) body_bytes[i] = 8'd0;
  endtask

  // Build the command that the kept payload bytes describe
  function automatic command_t decode_command();
    command_t    cmd;
    logic [31:0] type_word;
    logic [31:0] w [4];
    type_word = {body_bytes[3], body_bytes[2], body_bytes[1], body_bytes[0]};
    if (type_word == cfp_pkg::TYPE_TAKE)      cmd.kind = cfp_pkg::KIND_TAKE;
    else if (type_word == cfp_pkg::TYPE_LAND) cmd.kind = cfp_pkg::KIND_LAND;
    else if (type_word == cfp_pkg::TYPE_PCMD) cmd.kind = cfp_pkg::KIND_MOVE;
    else if (type_word == cfp_pkg::TYPE_ROTZ) cmd.kind = cfp_pkg::KIND_ROTATE;
    else                                      cmd.kind = cfp_pkg::KIND_UNKNOWN;
    for (int k = 0; k < 4; k++) begin
      w[k] = {body_bytes[4*k+7], body_bytes[4*k+6], body_bytes[4*k+5], body_bytes[4*k+4]};
    end
    cmd.value_a = w[0];
    cmd.value_b = w[1];
    cmd.value_c = w[2];
    cmd.value_d = w[3];
    // +0 and -0 do not count as motion
    cmd.moving = 1'b0;
    if (cmd.kind == cfp_pkg::KIND_MOVE) begin
      for (int k = 0; k < 4; k++) begin
        if (w[k][30:0] != 31'd0) cmd.moving = 1'b1;
      end
    end
    return cmd;
  endfunction

  // Advance the shadow parser by one received word
  task automatic parse_rx_byte(input logic [7:0] b);
    logic [7:0] sync_want;
    logic       frame_done;
    frame_done = 1'b0;
    case (parse_phase)
      PH_LEN: begin
        if (b >= min_len && b <= max_len) begin
          frame_len  = b;
          body_count = 8'd0;
          for (int i = 0; i < cfp_pkg::STORE_BYTES; i++) body_bytes[i] = 8'd0;
          if (b == 8'd0) begin
            parse_phase = PH_HUNT;
            sync_pos    = 2'd0;
            frame_done  = 1'b1;
          end else begin
            parse_phase = PH_DATA;
          end
        end else begin
          parse_phase = PH_HUNT;
          sync_pos    = 2'd0;
        end
      end
      PH_DATA: begin
        if (body_count < cfp_pkg::STORE_BYTES) body_bytes[body_count] = b;
        body_count = body_count + 8'd1;
        if (body_count == frame_len) begin
          parse_phase = PH_HUNT;
          sync_pos    = 2'd0;
          frame_done  = 1'b1;
        end
      end
      default: begin
        parse_phase = PH_HUNT;
        if (sync_pos > 2'd2) sync_pos = 2'd0;
        case (sync_pos)
          2'd0:    sync_want = cfp_pkg::SYNC_C;
          2'd1:    sync_want = cfp_pkg::SYNC_M;
          default: sync_want = cfp_pkg::SYNC_D;
        endcase
        if (b == sync_want) begin
          if (sync_pos == 2'd2) begin
            sync_pos    = 2'd0;
            parse_phase = PH_LEN;
          end else begin
            sync_pos = sync_pos + 2'd1;
          end
        end else if (b == cfp_pkg::SYNC_C) begin
          // a stray C may open a new sync word
          sync_pos = 2'd1;
        end else begin
          sync_pos = 2'd0;
        end
      end
    endcase
    if (frame_done) expected_commands.push_back(decode_command());
  endtask

  // Sender: one word offered at a time, random gaps
  always @(posedge clk) begin
    logic       next_valid;
    logic [7:0] next_byte;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || in_ready) begin
      next_valid = 1'b0;
      next_byte  = in_rx_byte;
      if (send_gap > 0) begin
        send_gap--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(1, 10) - 1;
      end else if (rx_stream.size() > 0) begin
        next_byte  = rx_stream.pop_front();
        next_valid = 1'b1;
      end
      in_valid <= next_valid;
      if (next_valid) in_rx_byte <= next_byte;
    end
  end

  // Track accepted words in the shadow parser
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      parse_rx_byte(in_rx_byte);
      words_taken++;
    end
  end

  // Receiver: random stalls plus one long hold-off to fill the block
  always @(posedge clk) begin
    logic next_ready;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      next_ready = 1'b1;
      if (!hold_done && words_taken >= HOLD_AT_WORD) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        next_ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(1, 10) - 1;
        next_ready = 1'b0;
      end
      out_ready <= next_ready;
    end
  end

  // Compare each accepted result with the oldest expected command
  always @(posedge clk) begin
    command_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_commands.size() == 0) begin
        report_error($sformatf("unexpected result kind %0d", out_kind));
      end else begin
        want = expected_commands.pop_front();
        commands_seen++;
        if (want.moving) moves_seen++;
        if (out_kind !== want.kind)
          report_error($sformatf("kind got %0d want %0d", out_kind, want.kind));
        if (out_value_a !== want.value_a)
          report_error($sformatf("value_a got %h want %h", out_value_a, want.value_a));
        if (out_value_b !== want.value_b)
          report_error($sformatf("value_b got %h want %h", out_value_b, want.value_b));
        if (out_value_c !== want.value_c)
          report_error($sformatf("value_c got %h want %h", out_value_c, want.value_c));
        if (out_value_d !== want.value_d)
          report_error($sformatf("value_d got %h want %h", out_value_d, want.value_d));
        if (out_moving !== want.moving)
          report_error($sformatf("moving got %b want %b", out_moving, want.moving));
      end
    end
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (psel && penable && pwrite && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  task automatic push_rx(input logic [7:0] b);
    rx_stream.push_back(b);
    words_queued++;
  endtask

  // Sync word, length word and a body of n_body words
  task automatic queue_frame(input logic [7:0] len_byte, input int n_body,
                             input int type_sel, input bit zero_vals);
    logic [31:0] tw;
    logic [31:0] vw [4];
    push_rx(cfp_pkg::SYNC_C);
    push_rx(cfp_pkg::SYNC_M);
    push_rx(cfp_pkg::SYNC_D);
    push_rx(len_byte);
    case (type_sel)
      0: tw = cfp_pkg::TYPE_TAKE;
      1: tw = cfp_pkg::TYPE_LAND;
      2: tw = cfp_pkg::TYPE_PCMD;
      3: tw = cfp_pkg::TYPE_ROTZ;
      4: tw = $urandom;
      default: begin
        // near miss: a known type with one bit flipped
        case ($urandom_range(0, 3))
          0: tw = cfp_pkg::TYPE_TAKE;
          1: tw = cfp_pkg::TYPE_LAND;
          2: tw = cfp_pkg::TYPE_PCMD;
          default: tw = cfp_pkg::TYPE_ROTZ;
        endcase
        tw = tw ^ (32'd1 << $urandom_range(0, 31));
      end
    endcase
    for (int k = 0; k < 4; k++) begin
      if (zero_vals) begin
        vw[k] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'd0;
      end else begin
        case ($urandom_range(0, 5))
          0: vw[k] = 32'd0;
          1: vw[k] = 32'h8000_0000;
          2: vw[k] = 32'd1 << $urandom_range(0, 31);
          default: vw[k] = $urandom;
        endcase
      end
    end
    for (int i = 0; i < n_body; i++) begin
      if (i < 4) push_rx(tw[8*i +: 8]);
      else if (i < cfp_pkg::STORE_BYTES) push_rx(vw[(i-4)/4][8*((i-4)%4) +: 8]);
      else push_rx(8'($urandom_range(0, 255)));
    end
  endtask

  // Mostly well-formed frames, some noise and broken sync, some bad lengths
  task automatic queue_random_frame();
    int span;
    int len;
    int n_body;
    int type_sel;
    case ($urandom_range(0, 9))
      0: for (int i = $urandom_range(1, 4); i > 0; i--) push_rx(8'($urandom_range(0, 255)));
      1: begin
        push_rx(cfp_pkg::SYNC_C);
        push_rx(cfp_pkg::SYNC_M);
      end
      2: push_rx(cfp_pkg::SYNC_C);
      3: begin
        push_rx(cfp_pkg::SYNC_C);
        push_rx(cfp_pkg::SYNC_M);
        push_rx(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    if (min_len <= max_len && $urandom_range(0, 7) != 0) begin
      span = max_len - min_len;
      if (span > 24 && $urandom_range(0, 29) != 0) span = 24;
      len    = min_len + $urandom_range(0, span);
      n_body = len;
    end else if (min_len > 0 && (max_len == 8'd255 || $urandom_range(0, 1) == 0)) begin
      len    = $urandom_range(0, min_len - 1);
      n_body = $urandom_range(0, 3);
    end else if (max_len < 8'd255) begin
      len    = $urandom_range(max_len + 1, 255);
      n_body = $urandom_range(0, 3);
    end else begin
      len    = $urandom_range(0, 24);
      n_body = len;
    end
    type_sel = $urandom_range(0, 6);
    if (type_sel == 6) type_sel = 2;
    queue_frame(8'(len), n_body, type_sel, type_sel == 2 && $urandom_range(0, 3) == 0);
  endtask

  task automatic fill_until(input int target);
    while (words_queued < target) queue_random_frame();
  endtask

  // Block idle: stream drained, nothing outstanding, then settle
  task automatic wait_idle();
    while (rx_stream.size() != 0 || in_valid || expected_commands.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_bound(input logic reg_idx, input logic [7:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == cfp_pkg::REG_MIN_LEN) min_len = val;
    else max_len = val;
    bound_writes++;
  endtask

  task automatic set_bounds(input logic [7:0] lo, input logic [7:0] hi);
    wait_idle();
    write_bound(cfp_pkg::REG_MIN_LEN, lo);
    write_bound(cfp_pkg::REG_MAX_LEN, hi);
  endtask

  initial begin
    clear_parser_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Default bounds: sync slips, each kind, bounds edges
    push_rx(cfp_pkg::SYNC_C);
    queue_frame(8'd4, 4, 0, 1'b0);
    push_rx(cfp_pkg::SYNC_C);
    push_rx(cfp_pkg::SYNC_M);
    queue_frame(8'd20, 20, 2, 1'b1);
    queue_frame(8'd3, 0, 1, 1'b0);
    queue_frame(8'd31, 0, 1, 1'b0);
    queue_frame(8'd30, 30, 3, 1'b0);
    queue_frame(8'd6, 6, 1, 1'b0);
    queue_frame(8'd12, 12, 5, 1'b0);
    fill_until(450);

    // Widest bounds: empty frames, short types, one full-length frame
    set_bounds(8'd0, 8'd255);
    queue_frame(8'd0, 0, 0, 1'b0);
    queue_frame(8'd255, 255, 2, 1'b0);
    fill_until(850);

    // Single allowed length
    set_bounds(8'd20, 8'd20);
    fill_until(950);

    // Crossed bounds: every frame is dropped
    set_bounds(8'd200, 8'd3);
    fill_until(1000);

    // Only the largest length, then only the empty frame
    set_bounds(8'd255, 8'd255);
    queue_frame(8'd255, 255, 0, 1'b0);
    set_bounds(8'd0, 8'd0);
    fill_until(1300);

    // Back to the reset bounds, full rate on both sides
    set_bounds(cfp_pkg::MIN_LEN_RST, cfp_pkg::MAX_LEN_RST);
    quiet = 1'b1;
    fill_until(1450);

    wait_idle();
    $display("Sent %0d words, checked %0d commands (%0d moving) over %0d bound writes",
             words_taken, commands_seen, moves_seen, bound_writes);
    $display("Covered sync slips, dropped lengths, empty, short and long frames");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
